[src/skt_pkg.sv]
package skt_pkg;

	localparam int KEY_W            = 40;
	localparam int PAY_W            = 32;
	localparam int STATUS_W         = 3;
	localparam int COUNT_W          = 6;
	// Wide enough to address the largest table the block supports.
	localparam int ADDR_W           = 6;
	localparam int DEFAULT_CAPACITY = 32;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_DELETE = 1'b1
	} req_type_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_WR,
		S_DEL_RD,
		S_DEL_CMP,
		S_STATUS,
		S_LIST_RD,
		S_LIST_LD
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
	} mem_req_t;

endpackage

[src/skt_req_if.sv]
interface skt_req_if import skt_pkg::*; ();

	logic             valid;
	logic             ready;
	logic             req_type;
	logic [KEY_W-1:0] key;
	logic [PAY_W-1:0] payload;

	modport source (output valid, output req_type, output key, output payload, input ready);
	modport sink (input valid, input req_type, input key, input payload, output ready);

endinterface

[src/skt_res_if.sv]
interface skt_res_if import skt_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  entry_count;
	logic                is_entry;
	logic [KEY_W-1:0]    entry_key;
	logic [PAY_W-1:0]    entry_payload;
	logic                last;

	modport source (
		output valid, output status, output entry_count, output is_entry,
		output entry_key, output entry_payload, output last, input ready
	);
	modport sink (
		input valid, input status, input entry_count, input is_entry,
		input entry_key, input entry_payload, input last, output ready
	);

endinterface

[src/skt_mem.sv]
module skt_mem import skt_pkg::*; #(
	parameter int DEPTH = DEFAULT_CAPACITY
) (
	input  logic     clk,
	input  mem_req_t mem_req,
	output entry_t   rd_data
);

	localparam int IW = $clog2(DEPTH);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// The read register holds its value until the next read is issued.
	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem_q[mem_req.wr_addr[IW-1:0]] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			rd_data_q <= mem_q[mem_req.rd_addr[IW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/sorted_key_table_insert_delete.sv]
// Sorted key table: holds up to CAPACITY records (40-bit key, 32-bit payload)
// in ascending key order in a single-port-read, single-port-write memory.
// Requests arrive on the req channel (insert or delete); every request yields
// a status transfer on the res channel followed by one transfer per held
// record, in ascending key order, with last marking the final transfer.
// An insert walks down from the top of the table, reading a record and then
// comparing it and, for a key that is not smaller, writing it back one place
// up, and ends by writing the new record. A delete walks up from the bottom
// over every record held, reading and then comparing each one and closing
// the gap as it goes. The status transfer follows, and the listing reads each
// record from memory and then loads it into the output register. Each record
// visited takes a read state and then a compare or load state, since the
// memory read is registered.
// A request is taken only when the previous one has been fully handed to the
// output register, but the next request may be taken while the final
// transfer of the previous one still waits in that register.
// When the receiver stalls, the output register holds its transfer and the
// listing pauses. Reset empties the table at once by clearing the record count;
// the memory contents are not cleared and entries above the count are never read.
module sorted_key_table_insert_delete import skt_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input logic     clk,
	input logic     arst_n,
	skt_req_if.sink req,
	skt_res_if.source res
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	// Control state.
	state_t        state_q, state_d;
	logic [CW-1:0] total_q, total_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_q, pos_d;
	logic          found_q, found_d;
	status_t       status_q, status_d;
	logic          out_valid_q;

	// Request held for the duration of the walk.
	logic [KEY_W-1:0] key_q, key_d;
	logic [PAY_W-1:0] pay_q, pay_d;

	// Output register.
	logic                out_load;
	logic                out_free;
	logic [STATUS_W-1:0] out_status_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                out_is_entry_q, out_is_entry_d;
	logic [KEY_W-1:0]    out_key_q, out_key_d;
	logic [PAY_W-1:0]    out_pay_q, out_pay_d;
	logic                out_last_q, out_last_d;

	mem_req_t mem_req;
	entry_t   rd_data;
	logic     found_now;

	skt_mem #(
		.DEPTH (CAPACITY)
	) u_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	assign out_free  = !out_valid_q || res.ready;
	assign req.ready = (state_q == S_IDLE);
	assign found_now = found_q || (rd_data.key == key_q);

	// Reads happen only in the read states and writes only in the compare
	// and write states, so no entry is read and written in the same cycle;
	// during a walk the write always lands one place behind the read.
	always_comb begin
		state_d        = state_q;
		total_d        = total_q;
		idx_d          = idx_q;
		pos_d          = pos_q;
		found_d        = found_q;
		status_d       = status_q;
		key_d          = key_q;
		pay_d          = pay_q;
		mem_req        = '0;
		out_load       = 1'b0;
		out_is_entry_d = 1'b0;
		out_key_d      = '0;
		out_pay_d      = '0;
		out_last_d     = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					key_d      = req.key;
					pay_d      = req.payload;
					found_d    = 1'b0;
					if (req.req_type == REQ_INSERT) begin
						if (total_q == CAP_C) begin
							status_d = ST_FULL;
							state_d  = S_STATUS;
						end else if (total_q == '0) begin
							pos_d   = '0;
							state_d = S_INS_WR;
						end else begin
							idx_d   = total_q - ONE_C;
							state_d = S_INS_RD;
						end
					end else begin
						if (total_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_STATUS;
						end else begin
							idx_d   = '0;
							state_d = S_DEL_RD;
						end
					end
				end
			end
			S_INS_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = ADDR_W'(idx_q);
				state_d         = S_INS_CMP;
			end
			S_INS_CMP: begin
				if (rd_data.key >= key_q) begin
					// Shift this record up one place to open the gap.
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = ADDR_W'(idx_q + ONE_C);
					mem_req.wr_data = rd_data;
					if (idx_q == '0) begin
						pos_d   = '0;
						state_d = S_INS_WR;
					end else begin
						idx_d   = idx_q - ONE_C;
						state_d = S_INS_RD;
					end
				end else begin
					pos_d   = idx_q + ONE_C;
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				mem_req.wr_en           = 1'b1;
				mem_req.wr_addr         = ADDR_W'(pos_q);
				mem_req.wr_data.key     = key_q;
				mem_req.wr_data.payload = pay_q;
				total_d                 = total_q + ONE_C;
				status_d                = ST_INSERTED;
				state_d                 = S_STATUS;
			end
			S_DEL_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = ADDR_W'(idx_q);
				state_d         = S_DEL_CMP;
			end
			S_DEL_CMP: begin
				if (found_q) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = ADDR_W'(idx_q - ONE_C);
					mem_req.wr_data = rd_data;
				end
				found_d = found_now;
				if (idx_q == total_q - ONE_C) begin
					if (found_now) begin
						total_d  = total_q - ONE_C;
						status_d = ST_DELETED;
					end else begin
						status_d = ST_NOT_FOUND;
					end
					state_d = S_STATUS;
				end else begin
					idx_d   = idx_q + ONE_C;
					state_d = S_DEL_RD;
				end
			end
			S_STATUS: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_last_d = (total_q == '0);
					idx_d      = '0;
					state_d    = (total_q == '0) ? S_IDLE : S_LIST_RD;
				end
			end
			S_LIST_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = ADDR_W'(idx_q);
				state_d         = S_LIST_LD;
			end
			S_LIST_LD: begin
				if (out_free) begin
					out_load       = 1'b1;
					out_is_entry_d = 1'b1;
					out_key_d      = rd_data.key;
					out_pay_d      = rd_data.payload;
					out_last_d     = (idx_q == total_q - ONE_C);
					idx_d          = idx_q + ONE_C;
					state_d        = out_last_d ? S_IDLE : S_LIST_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			found_q     <= 1'b0;
			status_q    <= ST_INSERTED;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			total_q  <= total_d;
			idx_q    <= idx_d;
			pos_q    <= pos_d;
			found_q  <= found_d;
			status_q <= status_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q      <= key_d;
		pay_q      <= pay_d;
		if (out_load) begin
			out_status_q   <= status_q;
			out_count_q    <= COUNT_W'(total_q);
			out_is_entry_q <= out_is_entry_d;
			out_key_q      <= out_key_d;
			out_pay_q      <= out_pay_d;
			out_last_q     <= out_last_d;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = out_status_q;
	assign res.entry_count   = out_count_q;
	assign res.is_entry      = out_is_entry_q;
	assign res.entry_key     = out_key_q;
	assign res.entry_payload = out_pay_q;
	assign res.last          = out_last_q;

	// The record count never passes the table size.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CAP_C)
		else $error("record count exceeds table size");

	// Memory writes stay inside the table.
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> (int'(mem_req.wr_addr) < CAPACITY))
		else $error("memory write outside table");

	// A status transfer is the final one exactly when the table is empty.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.is_entry) |-> (res.last == (res.entry_count == '0)))
		else $error("status transfer last flag disagrees with count");

	// A successful delete removes exactly one record.
	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL_CMP && state_d == S_STATUS && status_d == ST_DELETED)
		|=> (total_q == $past(total_q) - ONE_C))
		else $error("delete did not remove one record");

endmodule

[tb/tb_sorted_key_table_insert_delete.sv]
`timescale 1ns / 1ps

// The testbench drives requests into the sorted key table and checks every transfer that
// comes back. Each check compares against a prediction of the whole table that the
// testbench keeps itself, except for pinned rows, whose status and count are typed in.
module tb_sorted_key_table_insert_delete import skt_pkg::*; ();

	localparam int CAPACITY    = DEFAULT_CAPACITY;
	// The longest walk is an insert into a table one record short of full and then a full listing.
	// The settle time scales with the table size, plus slack.
	localparam int SETTLE_CYCLES = 4 * CAPACITY + 20;
	localparam int HOLD_CYCLES   = 300;

	// One transfer that the table is expected to send back.
	typedef struct packed {
		status_t              status;
		logic [COUNT_W-1:0]   count;
		logic                 is_entry;
		logic [KEY_W-1:0]     key;
		logic [PAY_W-1:0]     payload;
		logic                 last;
	} table_report_t;

	// One row of the directed stimulus. Where pinned is set, the status and
	// count of the request are typed in here. They are not taken from the predictor.
	typedef struct packed {
		req_type_t            op;
		logic [KEY_W-1:0]     key;
		logic [PAY_W-1:0]     payload;
		logic                 pinned;
		status_t              pin_status;
		logic [COUNT_W-1:0]   pin_count;
	} directed_row_t;

	localparam int DIRECTED_N = 23;

	logic clk;
	logic arst_n;

	skt_req_if req_ch ();
	skt_res_if res_ch ();

	sorted_key_table_insert_delete #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	// The testbench's own copy of the table. It is kept in ascending key order, exactly as
	// the block should keep it.
	logic [KEY_W-1:0] model_keys [CAPACITY];
	logic [PAY_W-1:0] model_pays [CAPACITY];
	int               model_total;

	table_report_t awaited_reports[$];
	int            mismatch_count;

	// Flags shared by the sender and the receiver. The no_idle flag turns off random gaps on
	// both sides. The hold_receiver flag asks the receiver for one long stall.
	bit no_idle;
	bit hold_receiver;

	// The directed part starts with deletes on an empty table. It then builds a small table
	// with duplicate keys at both extremes. A duplicate must land in front of its twin. It
	// then removes records one at a time, with further inserts and deletes of an absent key in
	// between. The last delete empties the table, and only the status transfer must come back.
	directed_row_t directed_rows [DIRECTED_N] = '{
		'{REQ_DELETE, 40'h00_0000_0000, 32'h0000_0000, 1'b1, ST_EMPTY,     6'd0},
		'{REQ_DELETE, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_EMPTY,     6'd0},
		'{REQ_INSERT, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_INSERTED,  6'd1},
		'{REQ_INSERT, 40'h00_0000_0000, 32'h0000_0000, 1'b1, ST_INSERTED,  6'd2},
		'{REQ_INSERT, 40'h00_0000_0000, 32'h0000_0001, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_INSERT, 40'hFF_FFFF_FFFF, 32'h0000_0000, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_DELETE, 40'h00_0000_0005, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 6'd4},
		'{REQ_DELETE, 40'h00_0000_0000, 32'hFFFF_FFFF, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_INSERT, 40'hAA_AAAA_AAAA, 32'h5555_5555, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_INSERT, 40'h55_5555_5555, 32'hAAAA_AAAA, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_INSERT, 40'h80_0000_0000, 32'h8000_0000, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_INSERT, 40'h00_0000_0001, 32'h0000_0001, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_DELETE, 40'hFF_FFFF_FFFF, 32'h0000_0000, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_DELETE, 40'hFF_FFFF_FFFF, 32'h0000_0000, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_DELETE, 40'hFF_FFFF_FFFF, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 6'd5},
		'{REQ_DELETE, 40'h00_0000_0000, 32'h0000_0000, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_DELETE, 40'h00_0000_0001, 32'h0000_0000, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_DELETE, 40'h55_5555_5555, 32'h0000_0000, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_DELETE, 40'h80_0000_0000, 32'h0000_0000, 1'b0, ST_INSERTED,  6'd0},
		'{REQ_DELETE, 40'hAA_AAAA_AAAA, 32'h0000_0000, 1'b1, ST_DELETED,   6'd0},
		'{REQ_DELETE, 40'h00_0000_0000, 32'h0000_0000, 1'b1, ST_EMPTY,     6'd0},
		'{REQ_INSERT, 40'h7F_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1, ST_INSERTED,  6'd1},
		'{REQ_DELETE, 40'h7F_FFFF_FFFF, 32'h0000_0000, 1'b1, ST_DELETED,   6'd0}
	};

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// This is the safety net: the run is cut off if the handshakes ever hang.
	initial begin
		#5_000_000;
		$display("tb_sorted_key_table_insert_delete NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// This applies one accepted request to the testbench's own table. It then queues every
	// transfer that the request should cause: first the status, then each held record in
	// ascending order. For a pinned row, the status and count come from the table of
	// stimulus. The listing always follows the prediction.
	function automatic void apply_request(input req_type_t op, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] payload, input logic pinned, input status_t pin_status,
			input logic [COUNT_W-1:0] pin_count);
		status_t            outcome;
		logic [COUNT_W-1:0] held;
		table_report_t      row;
		int                 pos;
		int                 i;

		pos = 0;
		if (op == REQ_INSERT) begin
			if (model_total >= CAPACITY) begin
				outcome = ST_FULL;
			end else begin
				// The new record goes in front of the first key that is not smaller, so the
				// newest of equal keys comes first.
				while (pos < model_total && model_keys[pos] < key) pos++;
				for (i = model_total; i > pos; i--) begin
					model_keys[i] = model_keys[i-1];
					model_pays[i] = model_pays[i-1];
				end
				model_keys[pos] = key;
				model_pays[pos] = payload;
				model_total++;
				outcome = ST_INSERTED;
			end
		end else begin
			if (model_total == 0) begin
				outcome = ST_EMPTY;
			end else begin
				while (pos < model_total && model_keys[pos] != key) pos++;
				if (pos >= model_total) begin
					outcome = ST_NOT_FOUND;
				end else begin
					for (i = pos; i + 1 < model_total; i++) begin
						model_keys[i] = model_keys[i+1];
						model_pays[i] = model_pays[i+1];
					end
					model_total--;
					outcome = ST_DELETED;
				end
			end
		end

		held = COUNT_W'(model_total);
		if (pinned) begin
			outcome = pin_status;
			held    = pin_count;
		end

		row.status   = outcome;
		row.count    = held;
		row.is_entry = 1'b0;
		row.key      = '0;
		row.payload  = '0;
		row.last     = (held == 0);
		awaited_reports.push_back(row);
		for (i = 0; i < model_total; i++) begin
			row.is_entry = 1'b1;
			row.key      = model_keys[i];
			row.payload  = model_pays[i];
			row.last     = (i + 1 == model_total);
			awaited_reports.push_back(row);
		end
	endfunction

	// This offers one request after a random gap and returns at the edge where the transfer
	// takes place. The prediction is made at that same edge, before any result can appear.
	// Valid gets a single assignment per edge. When the gap is zero it simply stays high for
	// the next request.
	task automatic send_request(input req_type_t op, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] payload, input logic pinned, input status_t pin_status,
			input logic [COUNT_W-1:0] pin_count);
		int gap;

		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= op;
		req_ch.key      <= key;
		req_ch.payload  <= payload;
		do @(posedge clk); while (!req_ch.ready);
		apply_request(op, key, payload, pinned, pin_status, pin_count);
	endtask

	// This lowers valid and waits until every queued transfer has arrived. It always waits at
	// least for a clock edge, so that the next request never lands in the same time step.
	task automatic wait_for_quiet();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited_reports.size() != 0);
	endtask

	// Keys favour records already held, so that deletes hit and inserts make duplicates.
	// Small keys and the two extremes also come up often. The rest are full 40-bit random
	// values.
	function automatic logic [KEY_W-1:0] pick_key(input bit prefer_held);
		logic [63:0] wide;
		int          r;

		r    = $urandom_range(0, 9);
		wide = {$urandom(), $urandom()};
		if (prefer_held && model_total > 0 && r < 6)
			return model_keys[$urandom_range(0, model_total - 1)];
		if (r == 6) return '0;
		if (r == 7) return '1;
		if (r == 8) return KEY_W'($urandom_range(0, 7));
		return wide[KEY_W-1:0];
	endfunction

	function automatic logic [PAY_W-1:0] pick_payload();
		int r;

		r = $urandom_range(0, 7);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return $urandom();
	endfunction

	task automatic send_random(input int insert_pct);
		req_type_t op;

		op = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
		send_request(op, pick_key(op == REQ_DELETE || $urandom_range(0, 3) == 0),
			pick_payload(), 1'b0, ST_INSERTED, '0);
	endtask

	// This is the receiving side. Before each result it stalls at random, unless no_idle is set.
	// When asked, it holds ready low for one long stretch. That lets the block's output back
	// up while the sender keeps offering requests. Every transfer is checked field by field
	// against the oldest transfer still awaited.
	initial begin
		table_report_t want;
		int            stall;

		res_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_receiver) begin
				stall         = HOLD_CYCLES;
				hold_receiver = 1'b0;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);

			if (awaited_reports.size() == 0) begin
				report_mismatch($sformatf("transfer with nothing awaited: key %0h payload %0h",
					res_ch.entry_key, res_ch.entry_payload));
			end else begin
				want = awaited_reports.pop_front();
				if (res_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						res_ch.status, want.status));
				if (res_ch.entry_count !== want.count)
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						res_ch.entry_count, want.count));
				if (res_ch.is_entry !== want.is_entry)
					report_mismatch($sformatf("is_entry %0b, expected %0b",
						res_ch.is_entry, want.is_entry));
				if (res_ch.entry_key !== want.key)
					report_mismatch($sformatf("entry_key %0h, expected %0h",
						res_ch.entry_key, want.key));
				if (res_ch.entry_payload !== want.payload)
					report_mismatch($sformatf("entry_payload %0h, expected %0h",
						res_ch.entry_payload, want.payload));
				if (res_ch.last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b",
						res_ch.last, want.last));
			end
		end
	end

	// This is the sending side. It also controls the run: reset, the directed table, the
	// random phases, and the final verdict.
	initial begin
		int fill_sent;
		int i;

		mismatch_count   = 0;
		model_total      = 0;
		no_idle          = 1'b0;
		hold_receiver    = 1'b0;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_INSERT;
		req_ch.key      <= '0;
		req_ch.payload  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIRECTED_N; i++) begin
			send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].payload,
				directed_rows[i].pinned, directed_rows[i].pin_status,
				directed_rows[i].pin_count);
		end
		wait_for_quiet();

		// This phase fills the table with inserts, mostly random, and a few deletes. Early on,
		// the receiver stalls for a long stretch. Then a burst of inserts runs into a full
		// table. Each of those must be dropped, and the table listed unchanged.
		fill_sent = 0;
		while (model_total < CAPACITY) begin
			if (fill_sent == 8) hold_receiver = 1'b1;
			send_random(90);
			fill_sent++;
		end
		repeat (5) send_random(100);
		wait_for_quiet();

		// This phase drains the table with deletes of held keys, taken at random places. It
		// finishes with deletes on an empty table.
		while (model_total > 0) begin
			send_request(REQ_DELETE, model_keys[$urandom_range(0, model_total - 1)],
				pick_payload(), 1'b0, ST_INSERTED, '0);
		end
		repeat (3) send_random(0);

		// This phase mixes inserts and deletes. The first stretch runs at full rate with no
		// gaps on either side.
		no_idle = 1'b1;
		repeat (4) send_random(55);
		no_idle = 1'b0;
		repeat (8) send_random(55);

		wait_for_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("tb_sorted_key_table_insert_delete OK");
		end else begin
			$display("tb_sorted_key_table_insert_delete NOT OK");
		end
		$finish;
	end

endmodule

[sorted_key_table_insert_delete.f]
src/skt_pkg.sv
src/skt_req_if.sv
src/skt_res_if.sv
src/skt_mem.sv
src/sorted_key_table_insert_delete.sv
tb/tb_sorted_key_table_insert_delete.sv
